### src/rrdp_pkg.sv
`timescale 1ns / 1ps

package rrdp_pkg;

  // player numbers 0..64 (0 is the bye marker), days 0..63
  localparam int unsigned PlayerW = 7;
  localparam int unsigned DayW    = 6;

  typedef logic [PlayerW-1:0] player_t;
  typedef logic [DayW-1:0]    day_t;

endpackage

### src/rrdp_req_if.sv
`timescale 1ns / 1ps

interface rrdp_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### src/rrdp_res_if.sv
`timescale 1ns / 1ps

interface rrdp_res_if
  import rrdp_pkg::*;
;
  logic    valid;
  logic    ready;
  day_t    day_index;
  player_t player_a;
  player_t player_b;
  logic    is_bye;
  logic    last_of_day;
  logic    schedule_done;

  modport source (
    output valid, output day_index, output player_a, output player_b,
    output is_bye, output last_of_day, output schedule_done,
    input  ready
  );
  modport sink (
    input  valid, input day_index, input player_a, input player_b,
    input  is_bye, input last_of_day, input schedule_done,
    output ready
  );
endinterface

### src/round_robin_day_pairing.sv
`timescale 1ns / 1ps
// sequence: a request word is taken in the idle state, then an evaluation state follows; a day of
// N players (padded to even) gives N/2 pair words, each built in a front-end and then a back-end lookup state
// a new day request is taken only once the day's last pair word or the done word has been registered
// the pace is set by output stalls and by the single shared ring lookup unit, used once for each end of a pair
// reset: player count 2, day 0, output register empty; a count write also restarts at day 0
module round_robin_day_pairing
  import rrdp_pkg::*;
#(
  parameter int unsigned MAX_PLAYERS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PlayerW-1:0] cfg_wdata_i,
  rrdp_req_if.sink           req_i,
  rrdp_res_if.source         res_o
);

  localparam player_t MaxPlayers = PlayerW'(MAX_PLAYERS);

  // sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEval  = 2'd1;
  localparam logic [1:0] StLookA = 2'd2;
  localparam logic [1:0] StLookB = 2'd3;

  logic [1:0] state_q, state_d;
  player_t    count_q;
  day_t       day_q, day_d;
  day_t       pair_q, pair_d;   // pair index within the day
  player_t    a_q;              // player from the front end of the ring

  // output register
  logic    out_valid_q;
  day_t    out_day_q;
  player_t out_a_q, out_b_q;
  logic    out_bye_q, out_last_q, out_done_q;

  // derived sizes: real players, padded ring size, rotating part, pairs per day
  player_t n_w;
  player_t ring_w;
  day_t    m_w;
  day_t    half_w;
  logic    too_few;
  logic    exhausted;
  logic    slot_free;

  assign n_w     = (count_q > MaxPlayers) ? MaxPlayers : count_q;
  assign ring_w  = n_w + {{(PlayerW-1){1'b0}}, n_w[0]};
  assign m_w     = DayW'(ring_w - 7'd1);
  assign half_w  = ring_w[PlayerW-1:1];
  assign too_few = (n_w < 7'd2);
  assign exhausted = too_few || ({1'b0, day_q} >= (ring_w - 7'd1));
  assign slot_free = !out_valid_q || res_o.ready;

  // shared ring lookup: position 0 is fixed, positions 1..N-1 have rotated by day_q
  // places, so entry p holds the start ring's entry at 1 + ((p-1-day) mod (N-1))
  player_t pos_w;
  day_t    rel_w;
  player_t diff_w;
  day_t    src_w;
  player_t look_w;

  assign pos_w  = (state_q == StLookA) ? {1'b0, pair_q}
                                       : (ring_w - 7'd1 - {1'b0, pair_q});
  assign rel_w  = DayW'(pos_w - 7'd1);
  assign diff_w = {1'b0, rel_w} - {1'b0, day_q};
  assign src_w  = diff_w[PlayerW-1] ? DayW'(diff_w + {1'b0, m_w}) : diff_w[DayW-1:0];

  always_comb begin
    if (pos_w == '0) begin
      look_w = 7'd1;
    end else if (({1'b0, src_w} + 7'd1) < n_w) begin
      look_w = {1'b0, src_w} + 7'd2;
    end else begin
      look_w = '0;   // bye marker
    end
  end

  logic pair_last;
  assign pair_last = ({1'b0, pair_q} == ({1'b0, half_w[DayW-1:0]} - 7'd1))
                     || (half_w == '0);

  // next-state logic
  always_comb begin
    state_d = state_q;
    day_d   = day_q;
    pair_d  = pair_q;
    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          state_d = StEval;
          if (req_i.restart) begin
            day_d = '0;
          end
        end
      end
      StEval: begin
        if (exhausted) begin
          if (slot_free) begin
            state_d = StIdle;
          end
        end else begin
          pair_d  = '0;
          state_d = StLookA;
        end
      end
      StLookA: begin
        state_d = StLookB;
      end
      StLookB: begin
        if (slot_free) begin
          if (pair_last) begin
            day_d   = day_q + 6'd1;
            state_d = StIdle;
          end else begin
            pair_d  = pair_q + 6'd1;
            state_d = StLookA;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // a count write reloads the ring, i.e. goes back to day 0
    if (cfg_we_i) begin
      day_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= 7'd2;
      day_q   <= '0;
      pair_q  <= '0;
    end else begin
      state_q <= state_d;
      day_q   <= day_d;
      pair_q  <= pair_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLookA) begin
      a_q <= look_w;
    end
  end

  // output word assembly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free && ((state_q == StLookB) || (state_q == StEval && exhausted))) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (state_q == StEval && exhausted) begin
        out_day_q  <= '0;
        out_a_q    <= '0;
        out_b_q    <= '0;
        out_bye_q  <= 1'b0;
        out_last_q <= 1'b0;
        out_done_q <= 1'b1;
      end else if (state_q == StLookB) begin
        out_day_q  <= day_q;
        out_bye_q  <= (a_q == '0) || (look_w == '0);
        out_last_q <= pair_last;
        out_done_q <= 1'b0;
        if (a_q == '0) begin
          out_a_q <= look_w;
          out_b_q <= '0;
        end else if (look_w == '0) begin
          out_a_q <= a_q;
          out_b_q <= '0;
        end else begin
          out_a_q <= a_q;
          out_b_q <= look_w;
        end
      end
    end
  end

  assign req_i.ready         = (state_q == StIdle);
  assign res_o.valid         = out_valid_q;
  assign res_o.day_index     = out_day_q;
  assign res_o.player_a      = out_a_q;
  assign res_o.player_b      = out_b_q;
  assign res_o.is_bye        = out_bye_q;
  assign res_o.last_of_day   = out_last_q;
  assign res_o.schedule_done = out_done_q;

`ifndef SYNTHESIS
  // the day counter never runs more than one past the last day of a valid schedule
  a_day_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !too_few |-> ({1'b0, day_q} <= (ring_w - 7'd1)))
    else $error("day counter beyond schedule");

  // pair lookups only run while the day still has pairs left
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookA || state_q == StLookB) |-> (pair_q < half_w[DayW-1:0]))
    else $error("pair index beyond half ring");

  // a bye pair always names the resting player in player_a only
  a_bye_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_bye) |-> (res_o.player_b == '0 && res_o.player_a != '0
                                        && !res_o.schedule_done))
    else $error("malformed bye word");

  // a day word is only produced once the sequencer reached the second lookup
  a_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && !out_done_q) |-> ($past(state_q) == StLookB))
    else $error("pair word from wrong sequencer state");
`endif

endmodule

### bench/pairing_checker.sv
`timescale 1ns / 1ps

module pairing_checker
  import rrdp_pkg::*;
#(
  parameter int unsigned MAX_PLAYERS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PlayerW-1:0] cfg_wdata_i,
  rrdp_req_if                req_i,
  rrdp_res_if                res_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        words_o,
  output int unsigned        byes_o,
  output int unsigned        done_o,
  output int unsigned        top_day_o
);

  typedef struct packed {
    day_t    day_index;
    player_t player_a;
    player_t player_b;
    logic    is_bye;
    logic    last_of_day;
    logic    schedule_done;
  } pair_word_t;

  player_t     seat [MAX_PLAYERS];
  player_t     count_reg   = player_t'(2);
  int unsigned days_played = 0;
  pair_word_t  pairs_due [$];
  int unsigned fails       = 0;
  int unsigned outstanding = 0;
  int unsigned words       = 0;
  int unsigned byes        = 0;
  int unsigned dones       = 0;
  int unsigned top_day     = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;
  assign words_o      = words;
  assign byes_o       = byes;
  assign done_o       = dones;
  assign top_day_o    = top_day;

  // counts above the ring size are clipped
  function automatic int unsigned players_in_use();
    int unsigned n;
    n = count_reg;
    return (n > MAX_PLAYERS) ? MAX_PLAYERS : n;
  endfunction

  function automatic void reseat();
    int unsigned n;
    int unsigned i;
    n = players_in_use();
    for (i = 0; i < MAX_PLAYERS; i++) begin
      seat[i] = (i < n) ? player_t'(i + 1) : '0;
    end
    days_played = 0;
  endfunction

  // one request: queue the day's pairs and turn every seat but the first, or queue a done word once exhausted
  function automatic void schedule_day(input logic restart);
    int unsigned n;
    int unsigned ring_n;
    int unsigned half;
    int unsigned i;
    player_t     a;
    player_t     b;
    player_t     last;
    pair_word_t  w;
    if (restart) begin
      reseat();
    end
    n      = players_in_use();
    ring_n = n + (n & 1);
    if (n < 2 || days_played >= ring_n - 1) begin
      w               = '0;
      w.schedule_done = 1'b1;
      pairs_due.insert(pairs_due.size(), w);
    end else begin
      half = ring_n / 2;
      for (i = 0; i < half; i++) begin
        a             = seat[i];
        b             = seat[ring_n - 1 - i];
        w             = '0;
        w.day_index   = day_t'(days_played);
        w.is_bye      = (a == '0) || (b == '0);
        w.player_a    = (a == '0) ? b : a;
        w.player_b    = w.is_bye ? player_t'(0) : b;
        w.last_of_day = (i == half - 1);
        pairs_due.insert(pairs_due.size(), w);
      end
      last = seat[ring_n - 1];
      for (i = ring_n - 1; i > 1; i--) begin
        seat[i] = seat[i - 1];
      end
      seat[1] = last;
      days_played++;
    end
  endfunction

  function automatic string show(input pair_word_t w);
    return $sformatf("day %0d a %0d b %0d bye %0b last %0b done %0b", w.day_index,
                     w.player_a, w.player_b, w.is_bye, w.last_of_day, w.schedule_done);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pair_word_t got;
    pair_word_t want;
    if (!rst_ni) begin
      count_reg = player_t'(2);
      reseat();
      pairs_due.delete();
    end else begin
      if (cfg_we_i) begin
        count_reg = cfg_wdata_i;
        reseat();
      end
      if (res_i.valid && res_i.ready) begin
        got.day_index     = res_i.day_index;
        got.player_a      = res_i.player_a;
        got.player_b      = res_i.player_b;
        got.is_bye        = res_i.is_bye;
        got.last_of_day   = res_i.last_of_day;
        got.schedule_done = res_i.schedule_done;
        words++;
        if (got.is_bye === 1'b1) byes++;
        if (got.schedule_done === 1'b1) begin
          dones++;
        end else if (got.day_index > top_day) begin
          top_day = got.day_index;
        end
        if (pairs_due.size() == 0) begin
          $display("%0t: unexpected pair word, expected none, got %s", $time, show(got));
          fails++;
        end else begin
          want = pairs_due.pop_front();
          if (got !== want) begin
            $display("%0t: pair word mismatch, expected %s, got %s", $time, show(want),
                     show(got));
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        schedule_day(req_i.restart);
      end
    end
    outstanding = pairs_due.size();
  end

endmodule

### bench/round_robin_day_pairing_tb.sv
`timescale 1ns / 1ps

module round_robin_day_pairing_tb
  import rrdp_pkg::*;
;

  localparam int unsigned MAX_PLAYERS  = 64;
  localparam int unsigned CLK_HALF     = 4;
  // hang guard bound, set well above the slowest legal run
  localparam int unsigned LIMIT_CYCLES = 600000;
  // long enough for the output side to back up into the request port
  localparam int unsigned HOLD_CYCLES  = 200;
  // longer than a full day at the largest ring
  localparam int unsigned TAIL_CYCLES  = 2 * MAX_PLAYERS + 8;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned CALM_ITEMS   = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  player_t     cfg_wdata;
  logic        calm;
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned fails;
  int unsigned pending;
  int unsigned words;
  int unsigned byes;
  int unsigned dones;
  int unsigned top_day;
  int unsigned requests_sent  = 0;
  int unsigned counts_written = 0;
  int unsigned cycles;

  rrdp_req_if req_if ();
  rrdp_res_if res_if ();

  always #(CLK_HALF) clk = ~clk;

  round_robin_day_pairing #(
    .MAX_PLAYERS (MAX_PLAYERS)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // the checker sees every accepted word on both sides and the count writes
  pairing_checker #(
    .MAX_PLAYERS (MAX_PLAYERS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .words_o      (words),
    .byes_o       (byes),
    .done_o       (dones),
    .top_day_o    (top_day)
  );

  // called at a falling edge; returns at the falling edge after the handshake,
  // leaving valid high so back-to-back words need no extra edge
  task automatic offer_word(input logic restart);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    @(negedge clk);
  endtask

  // drop the request and wait until every predicted pair word has come back
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // only called with the block idle; a write also restarts the schedule
  task automatic write_count(input player_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    counts_written++;
  endtask

  initial begin : stimulus
    int unsigned random_end;
    int unsigned len;
    int unsigned i;
    player_t     pick;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;
    calm           = 1'b0;
    hold_asks      = 0;
    rst_n          = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of two: one day, then exhausted, then a restart
    offer_word(1'b0);
    offer_word(1'b0);
    offer_word(1'b1);
    settle();
    // odd count: the bye marker pads the ring, run past the last day
    write_count(player_t'(3));
    offer_word(1'b0);
    offer_word(1'b0);
    offer_word(1'b0);
    offer_word(1'b0);
    offer_word(1'b1);
    settle();
    // too few players: every request gives a done word
    write_count(player_t'(0));
    offer_word(1'b0);
    offer_word(1'b1);
    settle();
    write_count(player_t'(1));
    offer_word(1'b0);
    settle();
    write_count(player_t'(4));
    offer_word(1'b1);
    offer_word(1'b0);
    offer_word(1'b0);
    offer_word(1'b0);
    settle();
    // largest ring, then counts above the maximum which clip to it
    write_count(player_t'(MAX_PLAYERS));
    offer_word(1'b0);
    offer_word(1'b0);
    settle();
    write_count(player_t'(127));
    offer_word(1'b0);
    settle();
    write_count(player_t'(MAX_PLAYERS + 1));
    offer_word(1'b1);
    settle();

    // total request budget before the closing stretch
    random_end = RANDOM_ITEMS - CALM_ITEMS;

    // back-pressure: the receiver stalls while requests keep coming, so the
    // output register fills and the request port has to stall too
    write_count(player_t'(8));
    calm      <= 1'b1;
    hold_asks <= hold_asks + 1;
    for (i = 0; i < 10; i++) begin
      offer_word(i == 0 || $urandom_range(0, 7) == 0);
    end
    settle();

    // one whole schedule at the largest ring, right through to exhaustion
    write_count(($urandom_range(0, 1) == 1) ? player_t'(MAX_PLAYERS)
                                            : player_t'($urandom_range(MAX_PLAYERS + 1, 127)));
    calm <= 1'b0;
    offer_word(1'b1);
    for (i = 0; i < MAX_PLAYERS; i++) begin
      offer_word(1'b0);
    end
    settle();

    // random phases: mostly small rings walked day by day, now and then a
    // restart in the middle, a few big or degenerate counts
    while (requests_sent < random_end) begin
      case ($urandom_range(0, 9))
        0:       pick = player_t'($urandom_range(MAX_PLAYERS, 127));
        1:       pick = player_t'($urandom_range(0, 1));
        default: pick = player_t'($urandom_range(2, 16));
      endcase
      write_count(pick);
      calm <= ($urandom_range(0, 3) == 0);
      len = (pick > 16) ? $urandom_range(2, 6) : $urandom_range(4, 24);
      for (i = 0; i < len; i++) begin
        offer_word((i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0));
      end
      settle();
    end

    // closing stretch with no idling on either side
    write_count(player_t'($urandom_range(2, 20)));
    calm <= 1'b1;
    for (i = 0; i < CALM_ITEMS; i++) begin
      offer_word((i == 0) || ($urandom_range(0, 7) == 0));
    end
    settle();
    // anything the block still sends now is flagged by the checker
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d day requests over %0d player count settings, empty to over-range",
             requests_sent, counts_written);
    $display("checked %0d pair words: %0d byes, %0d done words, days up to %0d",
             words, byes, dones, top_day);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: random stall bursts, none when calm, and one long hold on request
  initial begin : receiver
    int unsigned held;
    int unsigned gap;
    hold_served  = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        res_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
        end
        res_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // hang guard
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run stopped after %0d cycles, %0d pair words outstanding", $time,
             cycles, pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule
